>>> rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int MAX_THREADS = 16;
  localparam int NUM_LEVELS  = 4;

  localparam int OP_W        = 3;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int LEVEL_OUT_W = $clog2(NUM_LEVELS);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_QUANTUM = 3'd1,
    OP_YIELD   = 3'd2,
    OP_EXIT    = 3'd3,
    OP_BLOCK   = 3'd4,
    OP_WAKE    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    TS_FREE    = 2'd0,
    TS_READY   = 2'd1,
    TS_BLOCKED = 2'd2
  } tstate_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_HOLD
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
    logic load;
  } dp_cmd_t;

endpackage

>>> rtl/mlfq_in_if.sv
`timescale 1ns / 1ps
interface mlfq_in_if;
  import mlfq_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] thread_id;

  modport source (output valid, output operation, output thread_id, input ready);
  modport sink (input valid, input operation, input thread_id, output ready);
endinterface

>>> rtl/mlfq_out_if.sv
`timescale 1ns / 1ps
interface mlfq_out_if;
  import mlfq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ID_W-1:0]        running_id;
  logic                   running_valid;
  logic [LEVEL_OUT_W-1:0] running_level;
  logic                   error;

  modport source (output valid, output running_id, output running_valid,
                  output running_level, output error, input ready);
  modport sink (input valid, input running_id, input running_valid,
                input running_level, input error, output ready);
endinterface

>>> rtl/mlfq_ctrl.sv
`timescale 1ns / 1ps
module mlfq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mlfq_pkg::dp_cmd_t ctl
);
  import mlfq_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= ctl.load || (out_valid && !out_ready);
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.commit  = 1'b0;
    ctl.load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctl.commit = 1'b1;
        // hold the word if the previous result is still waiting
        if (out_free) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

>>> rtl/mlfq_dpath.sv
`timescale 1ns / 1ps
module mlfq_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  mlfq_pkg::dp_cmd_t                ctl,
  input  logic [mlfq_pkg::OP_W-1:0]        operation,
  input  logic [mlfq_pkg::ID_W-1:0]        thread_id,
  output logic [mlfq_pkg::ID_W-1:0]        running_id,
  output logic                             running_valid,
  output logic [mlfq_pkg::LEVEL_OUT_W-1:0] running_level,
  output logic                             error
);
  import mlfq_pkg::*;

  localparam int IW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(NUM_LEVELS);

  logic [IW-1:0] next_link    [MAX_THREADS];
  logic [LW-1:0] thread_level [MAX_THREADS];
  tstate_t       thread_state [MAX_THREADS];

  logic [IW-1:0]         queue_head [NUM_LEVELS];
  logic [IW-1:0]         queue_tail [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] queue_nonempty;
  logic [IW-1:0]         head_next [NUM_LEVELS];
  logic [IW-1:0]         tail_next [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty_next;

  // event captured at accept
  op_t           op;
  logic [IW-1:0] id;
  logic          refused;
  logic [IW-1:0] cur;
  logic [LW-1:0] cur_level;
  logic [IW-1:0] link_rd;
  logic [LW-1:0] level_rd;

  logic          id_ok;
  logic [IW-1:0] id_in;
  tstate_t       id_state;
  logic          refuse_in;

  logic          pick_valid;
  logic [LW-1:0] pick_level;
  logic [IW-1:0] pick_id;

  logic          do_pop;
  logic          app_en;
  logic [LW-1:0] app_level;
  logic [IW-1:0] app_id;
  logic [LW-1:0] raised;
  logic          link_we;
  logic [IW-1:0] link_addr;
  logic          lvl_we;
  logic [IW-1:0] lvl_addr;
  logic [LW-1:0] lvl_data;
  logic          st_we;
  logic [IW-1:0] st_addr;
  tstate_t       st_data;

  assign id_ok    = 32'(thread_id) < MAX_THREADS;
  assign id_in    = IW'(thread_id);
  assign id_state = thread_state[id_in];

  // Lowest-numbered non-empty queue; next values equal the registers outside commit
  always_comb begin
    pick_valid = 1'b0;
    pick_level = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (nonempty_next[l]) begin
        pick_valid = 1'b1;
        pick_level = LW'(l);
      end
    end
    pick_id = pick_valid ? head_next[pick_level] : '0;
  end

  always_comb begin
    unique case (op_t'(operation))
      OP_CREATE:  refuse_in = !id_ok || (id_state != TS_FREE);
      OP_QUANTUM,
      OP_YIELD,
      OP_EXIT,
      OP_BLOCK:   refuse_in = !pick_valid;
      OP_WAKE:    refuse_in = !id_ok || (id_state != TS_BLOCKED);
      default:    refuse_in = 1'b0;
    endcase
  end

  assign raised = (cur_level == LW'(NUM_LEVELS - 1)) ? cur_level : cur_level + LW'(1);

  always_comb begin
    do_pop    = 1'b0;
    app_en    = 1'b0;
    app_level = cur_level;
    app_id    = cur;
    lvl_we    = 1'b0;
    lvl_addr  = cur;
    lvl_data  = '0;
    st_we     = 1'b0;
    st_addr   = cur;
    st_data   = TS_READY;
    if (ctl.commit && !refused) begin
      unique case (op)
        OP_CREATE: begin
          app_en    = 1'b1;
          app_level = '0;
          app_id    = id;
          lvl_we    = 1'b1;
          lvl_addr  = id;
          st_we     = 1'b1;
          st_addr   = id;
        end
        OP_QUANTUM: begin
          do_pop    = 1'b1;
          app_en    = 1'b1;
          app_level = raised;
          lvl_we    = 1'b1;
          lvl_data  = raised;
        end
        OP_YIELD: begin
          do_pop = 1'b1;
          app_en = 1'b1;
        end
        OP_EXIT: begin
          do_pop  = 1'b1;
          lvl_we  = 1'b1;
          st_we   = 1'b1;
          st_data = TS_FREE;
        end
        OP_BLOCK: begin
          do_pop  = 1'b1;
          st_we   = 1'b1;
          st_data = TS_BLOCKED;
        end
        OP_WAKE: begin
          app_en    = 1'b1;
          app_level = level_rd;
          app_id    = id;
          st_we     = 1'b1;
          st_addr   = id;
        end
        default: ;
      endcase
    end
  end

  // Pop the running thread off its queue, then append
  always_comb begin
    head_next     = queue_head;
    tail_next     = queue_tail;
    nonempty_next = queue_nonempty;
    link_we       = 1'b0;
    link_addr     = '0;
    if (do_pop) begin
      if (queue_head[cur_level] == queue_tail[cur_level]) begin
        nonempty_next[cur_level] = 1'b0;
      end else begin
        head_next[cur_level] = link_rd;
      end
    end
    if (app_en) begin
      if (nonempty_next[app_level]) begin
        link_we   = 1'b1;
        link_addr = tail_next[app_level];
      end else begin
        head_next[app_level]     = app_id;
        nonempty_next[app_level] = 1'b1;
      end
      tail_next[app_level] = app_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_nonempty <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        queue_head[l] <= '0;
        queue_tail[l] <= '0;
      end
    end else begin
      queue_nonempty <= nonempty_next;
      queue_head     <= head_next;
      queue_tail     <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_THREADS; t++) begin
        thread_state[t] <= TS_FREE;
      end
    end else if (st_we) begin
      thread_state[st_addr] <= st_data;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      next_link[link_addr] <= app_id;
    end
    if (ctl.capture) begin
      link_rd <= next_link[pick_id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_THREADS; t++) begin
        thread_level[t] <= '0;
      end
    end else if (lvl_we) begin
      thread_level[lvl_addr] <= lvl_data;
    end
    if (ctl.capture) begin
      level_rd <= thread_level[id_in];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op        <= op_t'(operation);
      id        <= id_in;
      refused   <= refuse_in;
      cur       <= pick_id;
      cur_level <= pick_level;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      running_id    <= ID_W'(pick_id);
      running_valid <= pick_valid;
      running_level <= LEVEL_OUT_W'(pick_level);
      error         <= refused;
    end
  end
endmodule

>>> rtl/mlfq_thread_scheduler.sv
`timescale 1ns / 1ps
// Four-level feedback-queue thread scheduler. Each word on cmd is one event
// (create, quantum_expired, yield, exit, block, wake) and gives exactly one
// word on result: the thread that runs next, its queue level, and an error
// flag for refused events. When the result register is free, the accept
// cycle reads the link memory at the running thread, the next cycle commits
// the queue update and loads the result; cmd.ready returns in the cycle after
// that. While a result is not yet taken, the load waits in a hold state until
// result.ready frees the register. No clearing pass after reset.
module mlfq_thread_scheduler (
  input logic       clk,
  input logic       rst,
  mlfq_in_if.sink   cmd,
  mlfq_out_if.source result
);
  import mlfq_pkg::*;

  dp_cmd_t ctl;

  mlfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  mlfq_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .operation     (cmd.operation),
    .thread_id     (cmd.thread_id),
    .running_id    (result.running_id),
    .running_valid (result.running_valid),
    .running_level (result.running_level),
    .error         (result.error)
  );

`ifndef NO_ASSERTIONS
  a_capture_commits: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> ctl.commit)
    else $error("accepted event not committed");

  a_no_accept_in_commit: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> !cmd.ready)
    else $error("input ready during commit");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> result.valid)
    else $error("loaded result not presented");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.running_valid) |->
      (result.running_id == '0 && result.running_level == '0))
    else $error("empty schedule with nonzero id or level");
`endif
endmodule
